// File: rtl/core/ble_adv_spam_window_detector_top_defines.svh
// Assertion macros used by the detector controller.
`ifndef BLE_ADV_SPAM_WINDOW_DETECTOR_TOP_DEFINES_SVH
`define BLE_ADV_SPAM_WINDOW_DETECTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSWD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BSWD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BSWD_ASSERT_NOW(lbl, ante, cons)
`define BSWD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/bswd_pkg.sv
package bswd_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int MAC_W = 48;
	localparam int ENT_W = MAC_W + 2 + 8;

	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_CHECK   = 2'd3;

	localparam logic [1:0] KIND_CONT  = 2'd0;
	localparam logic [1:0] KIND_FAST  = 2'd1;
	localparam logic [1:0] KIND_SWIFT = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_THRESH = 1'b1;

	localparam logic signed [7:0] RSSI_MISSING = -8'sd100;
	localparam logic signed [7:0] RSSI_FLOOR   = -8'sd127;

	localparam logic [31:0] WINDOW_RESET = 32'd10000;
	localparam logic [6:0]  THRESH_RESET = 7'd5;

	typedef struct packed {
		logic in_ld;
		logic sight;
		logic exp_chk;
		logic inc_i;
		logic clr_i;
		logic pair_chk;
		logic ent_done;
		logic chk_done;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic last_i;
		logic j_at_i;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/ble_adv_spam_window_detector_top.sv
// Channel  Handshake                  Payload
// in       in_valid / in_ready        op, now_ms, addr_is_public, mac, mfr_*, fast_pair_service,
//                                     rssi_present, rssi
// out      out_valid / out_ready      status, alert_valid, alert_kind, distinct_macs,
//                                     strongest_rssi
// cfg      cfg_we, cfg_idx, cfg_data  window_ms (0), distinct_threshold (1)
//
// A sighting passes from accept through the dispatch and sighting states to the output register.
// A check runs an expiry sweep over every entry, with a read state and a write state per entry,
// then pairwise address compares over the table RAMs, each in a read state and a compare state,
// then a result state before the output register.
// One item is in work at a time; the next is accepted once the result is in the output register,
// so a result held by a low out_ready stalls the next item in its final state.
// Reset clears the valid bits and control; no clearing pass.
module ble_adv_spam_window_detector_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [31:0]       now_ms,
	input  logic              addr_is_public,
	input  logic [47:0]       mac,
	input  logic              mfr_present,
	input  logic [4:0]        mfr_len,
	input  logic [7:0]        mfr_byte0,
	input  logic [7:0]        mfr_byte1,
	input  logic [7:0]        mfr_byte2,
	input  logic              fast_pair_service,
	input  logic              rssi_present,
	input  logic signed [7:0] rssi,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic              alert_valid,
	output logic [1:0]        alert_kind,
	output logic [6:0]        distinct_macs,
	output logic signed [7:0] strongest_rssi,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [31:0]       cfg_data
);

	bswd_pkg::cmd_t cmd;
	bswd_pkg::sts_t sts;

	bswd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	bswd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.op(op), .now_ms(now_ms), .addr_is_public(addr_is_public), .mac(mac),
		.mfr_present(mfr_present), .mfr_len(mfr_len), .mfr_byte0(mfr_byte0),
		.mfr_byte1(mfr_byte1), .mfr_byte2(mfr_byte2),
		.fast_pair_service(fast_pair_service), .rssi_present(rssi_present), .rssi(rssi),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.alert_valid(alert_valid), .alert_kind(alert_kind),
		.distinct_macs(distinct_macs), .strongest_rssi(strongest_rssi)
	);

endmodule

// File: rtl/core/bswd_ram.sv
module bswd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/bswd_dp.sv
module bswd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bswd_pkg::cmd_t      cmd,
	output bswd_pkg::sts_t      sts,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [31:0]         cfg_data,
	input  logic                op,
	input  logic [31:0]         now_ms,
	input  logic                addr_is_public,
	input  logic [47:0]         mac,
	input  logic                mfr_present,
	input  logic [4:0]          mfr_len,
	input  logic [7:0]          mfr_byte0,
	input  logic [7:0]          mfr_byte1,
	input  logic [7:0]          mfr_byte2,
	input  logic                fast_pair_service,
	input  logic                rssi_present,
	input  logic signed [7:0]   rssi,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                alert_valid,
	output logic [1:0]          alert_kind,
	output logic [6:0]          distinct_macs,
	output logic signed [7:0]   strongest_rssi
);

	localparam int N = bswd_pkg::TABLE_ENTRIES;
	localparam int AW = bswd_pkg::IDX_W;

	logic [31:0] window_q;
	logic [6:0]  thr_q;

	logic              op_q;
	logic [31:0]       now_q;
	logic [47:0]       mac_q;
	logic [1:0]        kind_q;
	logic signed [7:0] str_q;

	logic [N-1:0]  valid_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic          seen_q;
	logic [6:0]        cnt_q  [3];
	logic signed [7:0] best_q [3];

	logic [1:0]        res_status_q;
	logic              res_alert_q;
	logic [1:0]        res_kind_q;
	logic [6:0]        res_cnt_q;
	logic signed [7:0] res_str_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              alert_q;
	logic [1:0]        akind_q;
	logic [6:0]        dcnt_q;
	logic signed [7:0] sstr_q;

	logic [1:0]  kind_in;
	logic        mfr_ok;
	logic [AW-1:0] free_idx;
	logic        full;
	logic        wr;
	logic [31:0] time_rd;
	logic [bswd_pkg::ENT_W-1:0] ent_a;
	logic [bswd_pkg::ENT_W-1:0] ent_b;
	logic [bswd_pkg::ENT_W-1:0] ent_wr;
	logic [47:0]       a_mac;
	logic [1:0]        a_kind;
	logic signed [7:0] a_str;
	logic [47:0]       b_mac;
	logic [1:0]        b_kind;
	logic              match;
	logic              hit;
	logic [1:0]        hit_kind;

	always_comb begin
		mfr_ok = mfr_present && (mfr_len >= 5'd3);
		if (addr_is_public) begin
			kind_in = bswd_pkg::KIND_NONE;
		end else if (mfr_ok && mfr_byte0 == 8'h4C && mfr_byte1 == 8'h00) begin
			kind_in = bswd_pkg::KIND_CONT;
		end else if (mfr_ok && mfr_byte0 == 8'h06 && mfr_byte1 == 8'h00 &&
				mfr_byte2 == 8'h03) begin
			kind_in = bswd_pkg::KIND_SWIFT;
		end else if (fast_pair_service) begin
			kind_in = bswd_pkg::KIND_FAST;
		end else begin
			kind_in = bswd_pkg::KIND_NONE;
		end
	end

	// first free slot, lowest index wins
	always_comb begin
		free_idx = '0;
		for (int k = N - 1; k >= 0; k--) begin
			if (!valid_q[k]) begin
				free_idx = AW'(k);
			end
		end
		full = &valid_q;
	end

	assign wr = cmd.sight && (kind_q != bswd_pkg::KIND_NONE) && !full;
	assign ent_wr = {mac_q, kind_q, str_q};

	bswd_ram #(.WIDTH(32), .DEPTH(N)) u_time_ram (
		.clk(clk), .we(wr), .waddr(free_idx), .wdata(now_q),
		.raddr(i_q), .rdata(time_rd)
	);

	bswd_ram #(.WIDTH(bswd_pkg::ENT_W), .DEPTH(N)) u_ent_ram_a (
		.clk(clk), .we(wr), .waddr(free_idx), .wdata(ent_wr),
		.raddr(i_q), .rdata(ent_a)
	);

	bswd_ram #(.WIDTH(bswd_pkg::ENT_W), .DEPTH(N)) u_ent_ram_b (
		.clk(clk), .we(wr), .waddr(free_idx), .wdata(ent_wr),
		.raddr(j_q), .rdata(ent_b)
	);

	assign {a_mac, a_kind, a_str} = ent_a;
	assign b_mac  = ent_b[bswd_pkg::ENT_W-1 -: 48];
	assign b_kind = ent_b[9:8];
	assign match  = valid_q[j_q] && (b_kind == a_kind) && (b_mac == a_mac);

	always_comb begin
		hit = 1'b0;
		hit_kind = bswd_pkg::KIND_CONT;
		for (int k = 2; k >= 0; k--) begin
			if (cnt_q[k] >= thr_q) begin
				hit = 1'b1;
				hit_kind = 2'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= bswd_pkg::WINDOW_RESET;
			thr_q    <= bswd_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == bswd_pkg::CFG_WINDOW) begin
				window_q <= cfg_data;
			end else begin
				thr_q <= cfg_data[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			op_q   <= op;
			now_q  <= now_ms;
			mac_q  <= mac;
			kind_q <= kind_in;
			str_q  <= rssi_present ? rssi : bswd_pkg::RSSI_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			seen_q  <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				cnt_q[k]  <= '0;
				best_q[k] <= bswd_pkg::RSSI_FLOOR;
			end
		end else begin
			if (cmd.in_ld) begin
				j_q    <= '0;
				seen_q <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					cnt_q[k]  <= '0;
					best_q[k] <= bswd_pkg::RSSI_FLOOR;
				end
			end
			if (cmd.clr_i) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + 1'b1;
			end
			if (wr) begin
				valid_q[free_idx] <= 1'b1;
			end
			// drop entries older than the window
			if (cmd.exp_chk && valid_q[i_q] && (now_q - time_rd) > window_q) begin
				valid_q[i_q] <= 1'b0;
			end
			if (cmd.pair_chk) begin
				seen_q <= seen_q | match;
				j_q    <= j_q + 1'b1;
			end
			if (cmd.ent_done) begin
				seen_q <= 1'b0;
				j_q    <= '0;
				if (valid_q[i_q] && a_kind != bswd_pkg::KIND_NONE) begin
					if (!seen_q) begin
						cnt_q[a_kind] <= cnt_q[a_kind] + 1'b1;
					end
					if (a_str > best_q[a_kind]) begin
						best_q[a_kind] <= a_str;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sight) begin
			res_alert_q <= 1'b0;
			res_kind_q  <= '0;
			res_cnt_q   <= '0;
			res_str_q   <= '0;
			if (kind_q == bswd_pkg::KIND_NONE) begin
				res_status_q <= bswd_pkg::ST_IGNORED;
			end else if (full) begin
				res_status_q <= bswd_pkg::ST_DROPPED;
			end else begin
				res_status_q <= bswd_pkg::ST_STORED;
			end
		end else if (cmd.chk_done) begin
			res_status_q <= bswd_pkg::ST_CHECK;
			res_alert_q  <= hit;
			res_kind_q   <= hit ? hit_kind : 2'd0;
			res_cnt_q    <= hit ? cnt_q[hit_kind] : 7'd0;
			res_str_q    <= hit ? best_q[hit_kind] : 8'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			status_q <= res_status_q;
			alert_q  <= res_alert_q;
			akind_q  <= res_kind_q;
			dcnt_q   <= res_cnt_q;
			sstr_q   <= res_str_q;
		end
	end

	assign sts.op       = op_q;
	assign sts.last_i   = (i_q == AW'(N - 1));
	assign sts.j_at_i   = (j_q == i_q);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign alert_valid    = alert_q;
	assign alert_kind     = akind_q;
	assign distinct_macs  = dcnt_q;
	assign strongest_rssi = sstr_q;

endmodule

// File: rtl/core/bswd_ctrl.sv
`include "ble_adv_spam_window_detector_top_defines.svh"

module bswd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bswd_pkg::sts_t sts,
	output bswd_pkg::cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_SIGHT    = 9'b000000100,
		S_EXP_RD   = 9'b000001000,
		S_EXP_WR   = 9'b000010000,
		S_PAIR_RD  = 9'b000100000,
		S_PAIR_CMP = 9'b001000000,
		S_RESULT   = 9'b010000000,
		S_FIN      = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_ld = 1'b1;
					cmd.clr_i = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = sts.op ? S_EXP_RD : S_SIGHT;
			end
			S_SIGHT: begin
				cmd.sight = 1'b1;
				state_d = S_FIN;
			end
			S_EXP_RD: begin
				state_d = S_EXP_WR;
			end
			S_EXP_WR: begin
				cmd.exp_chk = 1'b1;
				if (sts.last_i) begin
					cmd.clr_i = 1'b1;
					state_d = S_PAIR_RD;
				end else begin
					cmd.inc_i = 1'b1;
					state_d = S_EXP_RD;
				end
			end
			S_PAIR_RD: begin
				state_d = S_PAIR_CMP;
			end
			S_PAIR_CMP: begin
				if (!sts.j_at_i) begin
					cmd.pair_chk = 1'b1;
					state_d = S_PAIR_RD;
				end else begin
					cmd.ent_done = 1'b1;
					if (sts.last_i) begin
						state_d = S_RESULT;
					end else begin
						cmd.inc_i = 1'b1;
						state_d = S_PAIR_RD;
					end
				end
			end
			S_RESULT: begin
				cmd.chk_done = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`BSWD_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
	`BSWD_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_q == S_DISPATCH)
	`BSWD_ASSERT_NEXT(a_fin_leaves, state_q == S_FIN && sts.out_free, state_q == S_IDLE)

endmodule
